### rtl/lrc_pkg.sv
// Shared types and codes for the LRU/TTL result cache.
// Payload structs, request and register codes, walk control structs.
// No dependencies.
`default_nettype none
package lrc_pkg;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS      = 2'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [63:0]        key;
    logic signed [15:0] value_in;
    logic [31:0]        now_ms;
  } lrc_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] value_out;
    logic               expired;
    logic [4:0]         evicted_count;
  } lrc_out_t;

  typedef enum logic [1:0] {
    UPD_HIT    = 2'd0,
    UPD_EXPIRE = 2'd1,
    UPD_INSERT = 2'd2
  } lrc_upd_op_t;

  typedef struct packed {
    lrc_upd_op_t op;
    logic        found;
    logic        is_found;
    logic        ent_valid;
  } lrc_walk_ctl_t;

  typedef struct packed {
    logic match;
    logic rank_we;
    logic clr_valid;
    logic evict;
    logic free_slot;
  } lrc_walk_res_t;

endpackage
`default_nettype wire

### rtl/lru_ttl_result_cache.sv
// Top level of the LRU/TTL result cache: sequencer, valid bits, config.
// Depends on lrc_pkg, lrc_entry_ram and lrc_entry_alu.
`default_nettype none
// Fully associative result cache of DEPTH slots with LRU replacement and
// time-to-live expiry. Each input transfer is a lookup, insert or clear and
// yields exactly one result transfer. Lookups and inserts walk the entry
// store through its single read port, one slot per cycle: a search walk
// and a check state for the age compare, then, except for a lookup that
// misses, an update walk that rewrites recency ranks and drops evicted,
// replaced or expired slots; an insert then writes the new entry in a
// placement state. A clear or an unused request type goes from accept
// straight to the result state. A stalled result holds the result state
// until the output register frees. in_stall is high while an item is in
// flight. Valid bits are flip-flops cleared by reset, so no clearing pass
// follows reset. cfg_ready is always high; write max_entries and ttl_ms
// only while the block is idle.
module lru_ttl_result_cache #(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 64,
  parameter int TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lrc_pkg::lrc_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lrc_pkg::lrc_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW  = $clog2(DEPTH + 1);
  localparam int CW   = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int MW   = KEY_BITS + 16 + TIME_BITS + IW;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_CHECK  = 6'b000100,
    S_UPDATE = 6'b001000,
    S_PLACE  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  // control state
  state_t               state_r, state_nxt;
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [CNW-1:0]       count_r, count_nxt;
  logic [4:0]           max_r, max_nxt;
  logic [31:0]          ttl_r, ttl_nxt;
  logic                 found_r, found_nxt;
  logic                 free_found_r, free_found_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 iss_on_r, iss_on_nxt;
  logic                 d_on_r, d_on_nxt;

  // payload state
  lrc_pkg::lrc_in_t     req_r, req_nxt;
  lrc_pkg::lrc_upd_op_t op_r, op_nxt;
  logic [IW-1:0]        fidx_r, fidx_nxt;
  logic [IW-1:0]        frank_r, frank_nxt;
  logic signed [15:0]   fval_r, fval_nxt;
  logic [TIME_BITS-1:0] fstamp_r, fstamp_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic signed [15:0]   res_val_r, res_val_nxt;
  logic                 res_exp_r, res_exp_nxt;
  logic [CNW-1:0]       ev_r, ev_nxt;
  lrc_pkg::lrc_out_t    out_r, out_nxt;
  logic [IW-1:0]        iss_r, iss_nxt;
  logic [IW-1:0]        d_idx_r, d_idx_nxt;

  // entry store ports and unpacked read word
  logic                 mem_we;
  logic [IW-1:0]        mem_wa;
  logic [MW-1:0]        mem_wd;
  logic [MW-1:0]        mem_rd;
  logic [KEY_BITS-1:0]  d_key;
  logic signed [15:0]   d_val;
  logic [TIME_BITS-1:0] d_stamp;
  logic [IW-1:0]        d_rank;

  lrc_pkg::lrc_walk_ctl_t walk_ctl;
  lrc_pkg::lrc_walk_res_t walk_res;
  logic [IW-1:0]        new_rank;

  logic                 cap_full;
  logic [IW-1:0]        cap_m1;
  logic [KEY_BITS-1:0]  req_key;
  logic [TIME_BITS-1:0] req_now;
  logic [TIME_BITS-1:0] age;
  logic                 live;
  logic                 walk_start;
  logic                 walk_last;
  logic                 accept;

  assign d_key   = mem_rd[MW-1 -: KEY_BITS];
  assign d_val   = mem_rd[IW+TIME_BITS +: 16];
  assign d_stamp = mem_rd[IW +: TIME_BITS];
  assign d_rank  = mem_rd[IW-1:0];

  assign req_key = req_r.key[KEY_BITS-1:0];
  assign req_now = TIME_BITS'(req_r.now_ms);

  // A limit of zero or above the table depth means the full table.
  assign cap_full = (max_r == 5'd0) || (32'(max_r) > DEPTH);
  assign cap_m1   = cap_full ? LAST : IW'(max_r - 5'd1);

  // Wrapping age; zero TTL disables expiry.
  assign age  = req_now - fstamp_r;
  assign live = (ttl_r == 32'd0) || (CW'(age) <= CW'(ttl_r));

  assign walk_last = d_on_r && (d_idx_r == LAST);
  assign accept    = in_valid && !in_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign walk_ctl.op        = op_r;
  assign walk_ctl.found     = found_r;
  assign walk_ctl.is_found  = found_r && (d_idx_r == fidx_r);
  assign walk_ctl.ent_valid = valid_r[d_idx_r];

  lrc_entry_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (iss_r),
    .rd_data (mem_rd)
  );

  lrc_entry_alu #(
    .KEY_BITS (KEY_BITS),
    .IW       (IW)
  ) u_alu (
    .ctl      (walk_ctl),
    .ent_key  (d_key),
    .req_key  (req_key),
    .rank     (d_rank),
    .frank    (frank_r),
    .cap_m1   (cap_m1),
    .res      (walk_res),
    .new_rank (new_rank)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    max_nxt        = max_r;
    ttl_nxt        = ttl_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    req_nxt        = req_r;
    op_nxt         = op_r;
    fidx_nxt       = fidx_r;
    frank_nxt      = frank_r;
    fval_nxt       = fval_r;
    fstamp_nxt     = fstamp_r;
    free_idx_nxt   = free_idx_r;
    res_hit_nxt    = res_hit_r;
    res_val_nxt    = res_val_r;
    res_exp_nxt    = res_exp_r;
    ev_nxt         = ev_r;
    out_nxt        = out_r;
    walk_start     = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = d_idx_r;
    mem_wd         = {d_key, d_val, d_stamp, new_rank};

    // drop the held result once the sink takes it
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrc_pkg::CFG_MAX_ENTRIES: max_nxt = cfg_data[4:0];
        lrc_pkg::CFG_TTL_MS:      ttl_nxt = cfg_data;
        default:                  max_nxt = max_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt        = in_data;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          res_hit_nxt    = 1'b0;
          res_val_nxt    = -16'sd1;
          res_exp_nxt    = 1'b0;
          ev_nxt         = '0;
          case (in_data.req_type)
            lrc_pkg::REQ_LOOKUP, lrc_pkg::REQ_INSERT: begin
              walk_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            lrc_pkg::REQ_CLEAR: begin
              valid_nxt = '0;
              count_nxt = '0;
              state_nxt = S_RESULT;
            end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        // latch the first valid slot whose key matches
        if (d_on_r && walk_res.match && !found_r) begin
          found_nxt  = 1'b1;
          fidx_nxt   = d_idx_r;
          frank_nxt  = d_rank;
          fval_nxt   = d_val;
          fstamp_nxt = d_stamp;
        end
        if (walk_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (req_r.req_type == lrc_pkg::REQ_INSERT) begin
          op_nxt     = lrc_pkg::UPD_INSERT;
          walk_start = 1'b1;
          state_nxt  = S_UPDATE;
        end else if (!found_r) begin
          state_nxt = S_RESULT;
        end else if (live) begin
          res_hit_nxt = 1'b1;
          res_val_nxt = fval_r;
          op_nxt      = lrc_pkg::UPD_HIT;
          walk_start  = 1'b1;
          state_nxt   = S_UPDATE;
        end else begin
          res_exp_nxt = 1'b1;
          op_nxt      = lrc_pkg::UPD_EXPIRE;
          walk_start  = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (d_on_r) begin
          mem_we = walk_res.rank_we;
          if (walk_res.clr_valid) begin
            valid_nxt[d_idx_r] = 1'b0;
          end
          ev_nxt = ev_r + {{(CNW-1){1'b0}}, walk_res.evict};
          // remember the lowest slot that is free once this walk is done
          if (op_r == lrc_pkg::UPD_INSERT && !free_found_r && walk_res.free_slot) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = d_idx_r;
          end
        end
        if (walk_last) begin
          if (op_r == lrc_pkg::UPD_INSERT) begin
            state_nxt = S_PLACE;
          end else begin
            if (op_r == lrc_pkg::UPD_EXPIRE) begin
              count_nxt = count_r - CNW'(1);
            end
            state_nxt = S_RESULT;
          end
        end
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_wa    = free_idx_r;
        mem_wd    = {req_key, req_r.value_in, req_now, {IW{1'b0}}};
        valid_nxt[free_idx_r] = 1'b1;
        count_nxt = count_r - {{(CNW-1){1'b0}}, found_r} - ev_r + CNW'(1);
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.hit           = res_hit_r;
          out_nxt.value_out     = res_val_r;
          out_nxt.expired       = res_exp_r;
          out_nxt.evicted_count = 5'(ev_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // walk address generator: issue one read per cycle, data follows in the next cycle
  always_comb begin
    iss_nxt    = iss_r;
    iss_on_nxt = iss_on_r;
    if (walk_start) begin
      iss_nxt    = '0;
      iss_on_nxt = 1'b1;
    end else if (iss_on_r) begin
      iss_nxt = iss_r + IW'(1);
      if (iss_r == LAST) begin
        iss_on_nxt = 1'b0;
      end
    end
    d_on_nxt  = iss_on_r;
    d_idx_nxt = iss_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      count_r      <= '0;
      max_r        <= '0;
      ttl_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      iss_on_r     <= 1'b0;
      d_on_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      max_r        <= max_nxt;
      ttl_r        <= ttl_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
      iss_on_r     <= iss_on_nxt;
      d_on_r       <= d_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    op_r       <= op_nxt;
    fidx_r     <= fidx_nxt;
    frank_r    <= frank_nxt;
    fval_r     <= fval_nxt;
    fstamp_r   <= fstamp_nxt;
    free_idx_r <= free_idx_nxt;
    res_hit_r  <= res_hit_nxt;
    res_val_r  <= res_val_nxt;
    res_exp_r  <= res_exp_nxt;
    ev_r       <= ev_nxt;
    out_r      <= out_nxt;
    iss_r      <= iss_nxt;
    d_idx_r    <= d_idx_nxt;
  end

  // entry count tracks the valid bits whenever no item is in flight
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(valid_r) == int'(count_r)))
    else $error("entry count out of step with valid bits");

  // an insert always finds a free slot before it writes
  a_place_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> free_found_r)
    else $error("insert reached placement without a free slot");

  // an accepted transfer starts work on the next cycle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted transfer did not start a sequence");

  // a lookup result is never both a hit and an expiry
  a_hit_xor_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.expired))
    else $error("result flags both hit and expired");

endmodule
`default_nettype wire

### rtl/lrc_entry_ram.sv
// Entry store: one write port, one registered read port.
// Holds key, value, stamp and recency rank of every slot. No dependencies.
`default_nettype none
module lrc_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 120
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### rtl/lrc_entry_alu.sv
// Per-entry compare and rank update unit, shared by every walk step.
// Depends on lrc_pkg for the walk control and result structs.
`default_nettype none
module lrc_entry_alu #(
  parameter int KEY_BITS = 64,
  parameter int IW       = 4
) (
  input  wire lrc_pkg::lrc_walk_ctl_t ctl,
  input  wire logic [KEY_BITS-1:0]    ent_key,
  input  wire logic [KEY_BITS-1:0]    req_key,
  input  wire logic [IW-1:0]          rank,
  input  wire logic [IW-1:0]          frank,
  input  wire logic [IW-1:0]          cap_m1,
  output lrc_pkg::lrc_walk_res_t      res,
  output logic      [IW-1:0]          new_rank
);

  logic [IW-1:0] shifted;

  always_comb begin
    res       = '0;
    new_rank  = rank;
    res.match = ctl.ent_valid && (ent_key == req_key);
    shifted   = (ctl.found && (rank > frank)) ? rank - IW'(1) : rank;
    case (ctl.op)
      lrc_pkg::UPD_HIT: begin
        if (ctl.ent_valid) begin
          res.rank_we = 1'b1;
          if (ctl.is_found) begin
            new_rank = '0;
          end else if (rank < frank) begin
            new_rank = rank + IW'(1);
          end
        end
      end
      lrc_pkg::UPD_EXPIRE: begin
        if (ctl.ent_valid) begin
          if (ctl.is_found) begin
            res.clr_valid = 1'b1;
          end else if (rank > frank) begin
            res.rank_we = 1'b1;
            new_rank    = rank - IW'(1);
          end
        end
      end
      lrc_pkg::UPD_INSERT: begin
        if (ctl.ent_valid) begin
          if (ctl.is_found) begin
            res.clr_valid = 1'b1;
          end else if (shifted >= cap_m1) begin
            res.clr_valid = 1'b1;
            res.evict     = 1'b1;
          end else begin
            res.rank_we = 1'b1;
            new_rank    = shifted + IW'(1);
          end
        end
      end
      default: begin
        res.rank_we = 1'b0;
      end
    endcase
    res.free_slot = !ctl.ent_valid || res.clr_valid;
  end

endmodule
`default_nettype wire
